>>> rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool ring manager package
// Shared types, constants and helper functions for the slot ring blocks.
// ----------------------------------------------------------------------------
package spr_pkg;

	// Ring geometry
	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 5;
	localparam int LEN_W     = 16;
	localparam int ADDR_W    = 32;
	localparam int OVF_W     = 32;

	// Operation codes carried with each request
	typedef enum logic [1:0] {
		FUNC_QUERY   = 2'd0,
		FUNC_COMMIT  = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} spr_func_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_SLOT_SIZE    = 2'd1;
	localparam logic [1:0] CFG_SLOT_COUNT   = 2'd2;

	// Ring state as seen after one operation
	typedef struct packed {
		logic [SLOT_W-1:0] wr_slot;
		logic [SLOT_W-1:0] rd_slot;
		logic [LEN_W-1:0]  rd_len;
		logic [CNT_W-1:0]  used;
		logic [CNT_W-1:0]  free;
		logic [OVF_W-1:0]  ovf;
	} spr_view_t;

	// Clamp the configured slot count into 1..MAX_SLOTS.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] c;
		c = cnt;
		if (c == '0) begin
			c = CNT_W'(1);
		end
		if (c > CNT_W'(MAX_SLOTS)) begin
			c = CNT_W'(MAX_SLOTS);
		end
		return c;
	endfunction

	// Advance a slot index, wrapping at the effective count.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		n = {1'b0, idx} + CNT_W'(1);
		if (n >= cnt) begin
			return '0;
		end
		return n[SLOT_W-1:0];
	endfunction

endpackage

>>> rtl/core/spr_ctrl.sv
// ----------------------------------------------------------------------------
// Slot ring control
// Holds the write and read slots, occupancy, overflow count and length table,
// and applies one operation per step.
// ----------------------------------------------------------------------------
module spr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  spr_pkg::spr_func_t        func,
	input  logic [spr_pkg::LEN_W-1:0] length,
	input  logic [spr_pkg::CNT_W-1:0] slot_count,
	output spr_pkg::spr_view_t        view
);
	import spr_pkg::*;

	logic [SLOT_W-1:0] wr_q, wr_d;
	logic [SLOT_W-1:0] rd_q, rd_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [OVF_W-1:0]  ovf_q, ovf_d;
	logic [LEN_W-1:0]  len_q [MAX_SLOTS];
	logic [LEN_W-1:0]  len_d [MAX_SLOTS];
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  occ_mid;

	assign cnt = eff_count(slot_count);

	// Next state for the operation in flight.
	always_comb begin
		wr_d    = wr_q;
		rd_d    = rd_q;
		occ_d   = occ_q;
		ovf_d   = ovf_q;
		len_d   = len_q;
		occ_mid = occ_q;
		case (func)
			FUNC_COMMIT: begin
				// A full ring first drops its oldest slot.
				if (occ_q >= cnt) begin
					len_d[rd_q] = '0;
					rd_d        = next_slot(rd_q, cnt);
					ovf_d       = ovf_q + OVF_W'(1);
					if (occ_q != '0) begin
						occ_mid = occ_q - CNT_W'(1);
					end
				end
				len_d[wr_q] = length;
				wr_d        = next_slot(wr_q, cnt);
				occ_d       = occ_mid + CNT_W'(1);
			end
			FUNC_RELEASE: begin
				// Release on an empty ring leaves everything as it is.
				if (occ_q != '0) begin
					len_d[rd_q] = '0;
					rd_d        = next_slot(rd_q, cnt);
					occ_d       = occ_q - CNT_W'(1);
				end
			end
			FUNC_CLEAR: begin
				wr_d  = rd_q;
				occ_d = '0;
				ovf_d = '0;
				for (int i = 0; i < MAX_SLOTS; i++) begin
					len_d[i] = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// State after the operation, as reported in the result.
	always_comb begin
		view.wr_slot = wr_d;
		view.rd_slot = rd_d;
		view.rd_len  = len_d[rd_d];
		view.used    = occ_d;
		view.free    = (occ_d < cnt) ? (cnt - occ_d) : '0;
		view.ovf     = ovf_d;
	end

	// State registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
			ovf_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else if (step) begin
			wr_q  <= wr_d;
			rd_q  <= rd_d;
			occ_q <= occ_d;
			ovf_q <= ovf_d;
			len_q <= len_d;
		end
	end

endmodule

>>> rtl/core/spr_result.sv
// ----------------------------------------------------------------------------
// Slot ring result stage
// Turns slot indexes into addresses and holds the result for the output
// channel.
// ----------------------------------------------------------------------------
module spr_result (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  spr_pkg::spr_view_t         view,
	input  logic [spr_pkg::ADDR_W-1:0] base_address,
	input  logic [spr_pkg::LEN_W-1:0]  slot_size,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [127:0]               m_axis_tdata
);
	import spr_pkg::*;

	localparam int PROD_W = SLOT_W + LEN_W;

	logic [PROD_W-1:0] wr_off;
	logic [PROD_W-1:0] rd_off;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [127:0]      data_q;
	logic              valid_q;

	// Slot address is base plus index times slot size, modulo 2^32.
	assign wr_off  = PROD_W'(view.wr_slot) * PROD_W'(slot_size);
	assign rd_off  = PROD_W'(view.rd_slot) * PROD_W'(slot_size);
	assign wr_addr = base_address + ADDR_W'(wr_off);
	assign rd_addr = base_address + ADDR_W'(rd_off);

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {6'd0, view.ovf, view.free, view.used, view.rd_len, rd_addr, wr_addr};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

endmodule

>>> rtl/core/slot_pool_ring_manager.sv
// ----------------------------------------------------------------------------
// Slot pool ring manager
// Manages a ring of equal-size memory slots with per-slot lengths, reporting
// slot addresses, occupancy and overflow count after every operation.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tdata: length; tuser: func
//   m_axis    out        m_axis_tvalid/tready      tdata: result fields
//   cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; a result is
// presented once its request has passed the input register and been loaded
// into the result register. The ring state update and address generation
// form a single combinational pass between the two.
// Reset empties the ring and zeroes all stored lengths at once, with no
// clearing pass. An output stall holds the result and one pending request;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module slot_pool_ring_manager (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,  // [15:0] length
	input  logic [1:0]   s_axis_tuser,  // [1:0] func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] write_address, [63:32] read_address, [79:64] read_length,
	// [84:80] used_slots, [89:85] free_slots, [121:90] overflows, rest zero
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import spr_pkg::*;

	logic              valid_s1;
	spr_func_t         func_s1;
	logic [LEN_W-1:0]  length_s1;
	logic              advance;
	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  size_q;
	logic [CNT_W-1:0]  count_q;
	spr_view_t         view;

	// The pending request moves on when the result register is free.
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1   <= spr_func_t'(s_axis_tuser);
			length_s1 <= s_axis_tdata;
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= '0;
			count_q <= CNT_W'(MAX_SLOTS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE_ADDRESS: base_q  <= cfg_data;
				CFG_SLOT_SIZE:    size_q  <= cfg_data[LEN_W-1:0];
				CFG_SLOT_COUNT:   count_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	spr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.func       (func_s1),
		.length     (length_s1),
		.slot_count (count_q),
		.view       (view)
	);

	spr_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.view          (view),
		.base_address  (base_q),
		.slot_size     (size_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
